// ===== rtl/core/warp_register_scoreboard_assert.svh =====
// assertion macros for the warp register scoreboard
`ifndef WARP_REGISTER_SCOREBOARD_ASSERT_SVH
`define WARP_REGISTER_SCOREBOARD_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WRS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scoreboard check failed");
// next-cycle implication
`define WRS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scoreboard check failed");
`else
`define WRS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WRS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/wrs_pkg.sv =====
package wrs_pkg;

   localparam int unsigned WARPS_DEFAULT = 64;
   localparam int unsigned REGS_DEFAULT  = 256;

   localparam int unsigned CMD_W       = 3;
   localparam int unsigned WARP_W      = 6;
   localparam int unsigned REG_W       = 8;
   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned RSP_TDATA_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESERVE    = 3'd0,
      CMD_RELEASE    = 3'd1,
      CMD_CHECK      = 3'd2,
      CMD_PEND_QUERY = 3'd3,
      CMD_LONG_QUERY = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [WARP_W-1:0] warp_id;
      logic [REG_W-1:0]  reg_num;
      logic              long_load;
      logic              last;
   } item_type;

   typedef struct packed {
      logic error;
      logic long_op;
      logic any_pending;
      logic hazard;
   } result_type;

   typedef struct packed {
      logic row_we;
      logic count_we;
      logic hazard_next;
   } ctl_type;

endpackage

// ===== rtl/core/wrs_fwd_ram.sv =====
module wrs_fwd_ram #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   output logic [WIDTH-1:0]                    rd_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rdq_ff;
   logic             rd_valid_ff;
   logic [AW-1:0]    rd_addr_ff;
   logic             lw_valid_ff;
   logic [AW-1:0]    lw_addr_ff;
   logic [WIDTH-1:0] lw_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdq_ff      <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
   end

   // entries never written read as clear
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         lw_valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
         lw_valid_ff       <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lw_addr_ff <= wr_addr;
         lw_data_ff <= wr_data;
      end
   end

   // bypass the write that raced the registered read
   assign rd_data = (lw_valid_ff && (lw_addr_ff == rd_addr_ff)) ? lw_data_ff :
                    (rd_valid_ff ? rdq_ff : '0);

endmodule

// ===== rtl/core/wrs_exec.sv =====
module wrs_exec #(
   parameter int unsigned WARPS = 64,
   parameter int unsigned REGS  = 256
) (
   input  wrs_pkg::item_type             item,
   input  logic                          perfect_mode,
   input  logic                          hazard_acc,
   input  logic [2*WARPS-1:0]            row_rd,
   input  logic [$clog2(REGS+1)-1:0]     count_rd,
   output wrs_pkg::ctl_type              ctl,
   output wrs_pkg::result_type           res,
   output logic [2*WARPS-1:0]            row_wr,
   output logic [$clog2(REGS+1)-1:0]     count_wr
);

   localparam int unsigned CW  = $clog2(REGS + 1);
   localparam int unsigned WAW = (WARPS > 1) ? $clog2(WARPS) : 1;

   logic             wok;
   logic             rok;
   logic [WAW-1:0]   widx;
   logic [WARPS-1:0] pend_row;
   logic [WARPS-1:0] long_row;
   logic [WARPS-1:0] pend_new;
   logic [WARPS-1:0] long_new;
   logic [CW-1:0]    count_new;
   logic             pend;
   logic             hazard;
   logic             err;

   assign wok = {1'b0, item.warp_id} < (wrs_pkg::WARP_W+1)'(WARPS);
   assign rok = wok && (item.reg_num != '0) &&
                ({1'b0, item.reg_num} < (wrs_pkg::REG_W+1)'(REGS));
   assign widx     = wok ? item.warp_id[WAW-1:0] : '0;
   assign pend_row = row_rd[WARPS-1:0];
   assign long_row = row_rd[2*WARPS-1:WARPS];
   assign pend     = rok && pend_row[widx];

   always_comb begin
      pend_new        = pend_row;
      long_new        = long_row;
      count_new       = count_rd;
      ctl.row_we      = 1'b0;
      ctl.count_we    = 1'b0;
      ctl.hazard_next = hazard_acc;
      hazard          = 1'b0;
      err             = 1'b0;
      case (wrs_pkg::cmd_type'(item.cmd))
         wrs_pkg::CMD_RESERVE: begin
            if (rok) begin
               ctl.row_we = 1'b1;
               if (pend) begin
                  err = !perfect_mode;
               end else begin
                  pend_new[widx] = 1'b1;
                  count_new      = count_rd + CW'(1);
                  ctl.count_we   = 1'b1;
               end
               if (item.long_load) begin
                  long_new[widx] = 1'b1;
               end
            end
         end
         wrs_pkg::CMD_RELEASE: begin
            if (rok) begin
               ctl.row_we     = 1'b1;
               long_new[widx] = 1'b0;
               if (pend) begin
                  pend_new[widx] = 1'b0;
                  if (count_rd != '0) begin
                     count_new    = count_rd - CW'(1);
                     ctl.count_we = 1'b1;
                  end
               end
            end
         end
         wrs_pkg::CMD_CHECK: begin
            hazard          = hazard_acc | pend;
            ctl.hazard_next = item.last ? 1'b0 : hazard;
         end
         default: begin
         end
      endcase
   end

   assign row_wr          = {long_new, pend_new};
   assign count_wr        = count_new;
   assign res.hazard      = hazard;
   assign res.any_pending = wok && (count_new != '0);
   assign res.long_op     = rok && long_new[widx];
   assign res.error       = err;

endmodule

// ===== rtl/core/warp_register_scoreboard.sv =====
// an accepted transaction is registered in the input stage, its result in the result stage
// throughput: one transaction per cycle unless rsp_ stalls, set by a read-modify-write of
// one scoreboard row and one warp count per cycle, the last write bypassed to the next read
// reset: synchronous, active high; clears control, the check-run flag and the mode bit
// scoreboard rows and counts carry valid bits, so no clearing pass is needed after reset
`include "warp_register_scoreboard_assert.svh"

module warp_register_scoreboard #(
   parameter int unsigned WARPS = wrs_pkg::WARPS_DEFAULT,
   parameter int unsigned REGS  = wrs_pkg::REGS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration: perfect_data_mode
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // cmd[2:0], warp_id[8:3], reg_num[16:9], long_load[17], zero[23:18]
   input  logic [wrs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hazard[0], any_pending[1], long_op[2], error[3], zero[7:4]
   output logic [wrs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int unsigned CW  = $clog2(REGS + 1);
   localparam int unsigned WAW = (WARPS > 1) ? $clog2(WARPS) : 1;
   localparam int unsigned RAW = (REGS > 1) ? $clog2(REGS) : 1;

   // handshake
   logic req_accept;
   logic rsp_free;
   logic s1_fire;

   // mode bit
   logic perfect_ff;
   logic perfect_in;

   // input register stage
   logic              s1_valid_ff;
   logic              s1_valid_in;
   wrs_pkg::item_type s1_item_ff;
   wrs_pkg::item_type s1_item_in;
   wrs_pkg::item_type req_item;

   // result register stage
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   wrs_pkg::result_type rsp_res_ff;
   wrs_pkg::result_type rsp_res_in;

   // check-run accumulator
   logic hazard_acc_ff;
   logic hazard_acc_in;

   // store addressing
   logic           req_wok;
   logic           req_rok;
   logic [WAW-1:0] req_widx;
   logic [RAW-1:0] req_ridx;
   logic           s1_wok;
   logic           s1_rok;
   logic [WAW-1:0] s1_widx;
   logic [RAW-1:0] s1_ridx;

   // store data
   logic [2*WARPS-1:0]  row_rd;
   logic [2*WARPS-1:0]  row_wr;
   logic [CW-1:0]       count_rd;
   logic [CW-1:0]       count_wr;
   wrs_pkg::ctl_type    exec_ctl;
   wrs_pkg::result_type exec_res;

   // unpack the request transaction
   assign req_item.cmd       = req_tdata[2:0];
   assign req_item.warp_id   = req_tdata[8:3];
   assign req_item.reg_num   = req_tdata[16:9];
   assign req_item.long_load = req_tdata[17];
   assign req_item.last      = req_tlast;

   // the result register frees up as soon as its transaction is taken
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_accept = req_tvalid && req_tready;

   // a warp or register out of range reads entry zero and is masked downstream
   assign req_wok  = {1'b0, req_item.warp_id} < (wrs_pkg::WARP_W+1)'(WARPS);
   assign req_rok  = req_wok && (req_item.reg_num != '0) &&
                     ({1'b0, req_item.reg_num} < (wrs_pkg::REG_W+1)'(REGS));
   assign req_widx = req_wok ? req_item.warp_id[WAW-1:0] : '0;
   assign req_ridx = req_rok ? req_item.reg_num[RAW-1:0] : '0;

   assign s1_wok  = {1'b0, s1_item_ff.warp_id} < (wrs_pkg::WARP_W+1)'(WARPS);
   assign s1_rok  = s1_wok && (s1_item_ff.reg_num != '0) &&
                    ({1'b0, s1_item_ff.reg_num} < (wrs_pkg::REG_W+1)'(REGS));
   assign s1_widx = s1_wok ? s1_item_ff.warp_id[WAW-1:0] : '0;
   assign s1_ridx = s1_rok ? s1_item_ff.reg_num[RAW-1:0] : '0;

   // pending row in the low half, long-latency row in the high half
   wrs_fwd_ram #(
      .DEPTH (REGS),
      .WIDTH (2 * WARPS)
   ) u_row_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_ridx),
      .wr_en   (s1_fire && exec_ctl.row_we),
      .wr_addr (s1_ridx),
      .wr_data (row_wr),
      .rd_data (row_rd)
   );

   // pending register count per warp
   wrs_fwd_ram #(
      .DEPTH (WARPS),
      .WIDTH (CW)
   ) u_count_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_widx),
      .wr_en   (s1_fire && exec_ctl.count_we),
      .wr_addr (s1_widx),
      .wr_data (count_wr),
      .rd_data (count_rd)
   );

   wrs_exec #(
      .WARPS (WARPS),
      .REGS  (REGS)
   ) u_exec (
      .item         (s1_item_ff),
      .perfect_mode (perfect_ff),
      .hazard_acc   (hazard_acc_ff),
      .row_rd       (row_rd),
      .count_rd     (count_rd),
      .ctl          (exec_ctl),
      .res          (exec_res),
      .row_wr       (row_wr),
      .count_wr     (count_wr)
   );

   // next-state logic
   always_comb begin
      perfect_in    = csr_wr_en ? csr_wr_data : perfect_ff;
      hazard_acc_in = s1_fire ? exec_ctl.hazard_next : hazard_acc_ff;

      s1_item_in  = req_accept ? req_item : s1_item_ff;
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_res_in   = s1_fire ? exec_res : rsp_res_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         perfect_ff    <= 1'b0;
         hazard_acc_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         perfect_ff    <= perfect_in;
         hazard_acc_ff <= hazard_acc_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_res_ff.error, rsp_res_ff.long_op,
                        rsp_res_ff.any_pending, rsp_res_ff.hazard};

   // error can only come from a reserve
   `WRS_ASSERT_IMP(a_error_from_reserve, clock, reset, s1_fire && exec_res.error, s1_item_ff.cmd == wrs_pkg::CMD_RESERVE)
   // hazard can only come from a check
   `WRS_ASSERT_IMP(a_hazard_from_check, clock, reset, s1_fire && exec_res.hazard, s1_item_ff.cmd == wrs_pkg::CMD_CHECK)
   // the last operand of a run closes the run
   `WRS_ASSERT_NXT(a_run_end_clears, clock, reset, s1_fire && (s1_item_ff.cmd == wrs_pkg::CMD_CHECK) && s1_item_ff.last, !hazard_acc_ff)
   // a new transaction over a full stage means that stage moves on
   `WRS_ASSERT_IMP(a_full_stage_moves, clock, reset, req_accept && s1_valid_ff, s1_fire)

endmodule
